@@ rtl/srrr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrr_pkg
// Shared types and constants for the selective-repeat receive reorder block.
// ----------------------------------------------------------------------------
package srrr_pkg;

  localparam int MAX_WINDOW   = 8;
  localparam int PAYLOAD_BITS = 32;
  localparam int SLOTS        = 2 * MAX_WINDOW;
  localparam int SLOT_AW      = $clog2(SLOTS);

  // fixed field widths
  localparam int SEQ_W  = 4;
  localparam int WIN_W  = 4;
  localparam int KIND_W = 2;
  // sequence space / distance arithmetic, holds up to 2*window
  localparam int SPC_W  = WIN_W + 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_DELIVER = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_CLOSE   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DELIV,
    ST_ACK,
    ST_LDELIV,
    ST_LACK,
    ST_LCLOSE
  } state_e;

  typedef struct packed {
    logic                    we;
    logic [SLOT_AW-1:0]      waddr;
    logic [PAYLOAD_BITS-1:0] wdata;
    logic                    re;
    logic [SLOT_AW-1:0]      raddr;
  } ram_req_t;

endpackage

@@ rtl/srrr_slot_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrr_slot_mem
// Payload slot storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module srrr_slot_mem
  import srrr_pkg::*;
(
  input  logic                    clk_i,
  input  ram_req_t                req_i,
  output logic [PAYLOAD_BITS-1:0] rd_data_o
);

  logic [PAYLOAD_BITS-1:0] mem [SLOTS];
  logic [PAYLOAD_BITS-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    // read data holds while no read is issued
    if (req_i.re) begin
      rd_q <= mem[req_i.raddr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

@@ rtl/srrr_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrr_ctrl
// Window control: base pointer, slot-full bits, drain sequencer, result reg.
// ----------------------------------------------------------------------------
module srrr_ctrl
  import srrr_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [WIN_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [SEQ_W-1:0]        seq_num_i,
  input  logic                    is_last_i,
  input  logic [PAYLOAD_BITS-1:0] payload_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [KIND_W-1:0]       result_kind_o,
  output logic [SEQ_W-1:0]        seq_out_o,
  output logic [PAYLOAD_BITS-1:0] data_out_o,
  output logic                    last_of_run_o,
  output ram_req_t                ram_req_o,
  input  logic [PAYLOAD_BITS-1:0] ram_rd_i
);

  state_e                  state_q, state_d;
  logic [WIN_W-1:0]        win_q, win_d;
  logic [SEQ_W-1:0]        base_q, base_d;
  logic [SLOTS-1:0]        full_q, full_d;
  logic [SLOT_AW-1:0]      idx_q, idx_d;
  logic [WIN_W-1:0]        cnt_q, cnt_d;
  logic [SEQ_W-1:0]        seq_q, seq_d;
  logic                    last_q, last_d;
  logic [PAYLOAD_BITS-1:0] data_q, data_d;

  logic                    ov_q, ov_d;
  kind_e                   okind_q, okind_d;
  logic [SEQ_W-1:0]        oseq_q, oseq_d;
  logic [PAYLOAD_BITS-1:0] odata_q, odata_d;
  logic                    olast_q, olast_d;

  logic [WIN_W-1:0] w_eff;
  logic [SPC_W-1:0] space, seq5, base5, ahead;
  logic [SPC_W-1:0] idx_nx;
  logic             in_win, can_load, in_acc, cfg_acc;

  // active window: zero means one, large values saturate
  always_comb begin
    if (win_q == '0) begin
      w_eff = WIN_W'(1);
    end else if (win_q > WIN_W'(MAX_WINDOW)) begin
      w_eff = WIN_W'(MAX_WINDOW);
    end else begin
      w_eff = win_q;
    end
  end

  assign space  = {w_eff, 1'b0};
  assign seq5   = SPC_W'(seq_num_i);
  assign base5  = SPC_W'(base_q);
  assign ahead  = (seq5 >= base5) ? (seq5 - base5) : (seq5 + space - base5);
  assign in_win = (seq5 < space) && (ahead < SPC_W'(w_eff));
  assign idx_nx = SPC_W'(idx_q) + SPC_W'(1);

  assign can_load    = !ov_q || !out_stall_i;
  // a window write has priority: hold the packet beat off meanwhile
  assign in_stall_o  = (state_q != ST_IDLE) || cfg_valid_i;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  always_comb begin
    state_d = state_q;
    win_d   = win_q;
    base_d  = base_q;
    full_d  = full_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    seq_d   = seq_q;
    last_d  = last_q;
    data_d  = data_q;
    okind_d = okind_q;
    oseq_d  = oseq_q;
    odata_d = odata_q;
    olast_d = olast_q;
    ov_d    = ov_q && out_stall_i;
    ram_req_o = '0;

    case (state_q)
      ST_IDLE: begin
        if (cfg_acc) begin
          win_d  = cfg_data_i;
          base_d = '0;
          full_d = '0;
        end else if (in_acc) begin
          seq_d  = seq_num_i;
          last_d = is_last_i;
          data_d = payload_i;
          if (is_last_i) begin
            if (seq_num_i == base_q) begin
              state_d = ST_LDELIV;
            end
          end else if (in_win) begin
            ram_req_o.we    = 1'b1;
            ram_req_o.waddr = SLOT_AW'(seq_num_i);
            ram_req_o.wdata = payload_i;
            full_d[SLOT_AW'(seq_num_i)] = 1'b1;
            if (ahead == '0) begin
              idx_d   = SLOT_AW'(base_q);
              cnt_d   = '0;
              state_d = ST_ISSUE;
            end else begin
              state_d = ST_ACK;
            end
          end else begin
            state_d = ST_ACK;
          end
        end
      end
      ST_ISSUE: begin
        if ((cnt_q < w_eff) && full_q[idx_q]) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = idx_q;
          state_d = ST_DELIV;
        end else begin
          base_d  = SEQ_W'(idx_q);
          state_d = ST_ACK;
        end
      end
      ST_DELIV: begin
        if (can_load) begin
          ov_d    = 1'b1;
          okind_d = KIND_DELIVER;
          oseq_d  = SEQ_W'(idx_q);
          odata_d = ram_rd_i;
          olast_d = 1'b0;
          full_d[idx_q] = 1'b0;
          cnt_d   = cnt_q + WIN_W'(1);
          idx_d   = (idx_nx == space) ? '0 : SLOT_AW'(idx_nx);
          state_d = ST_ISSUE;
        end
      end
      ST_ACK: begin
        if (can_load) begin
          ov_d    = 1'b1;
          okind_d = KIND_ACK;
          oseq_d  = seq_q;
          odata_d = '0;
          olast_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_LDELIV: begin
        if (can_load) begin
          ov_d    = 1'b1;
          okind_d = KIND_DELIVER;
          oseq_d  = seq_q;
          odata_d = data_q;
          olast_d = 1'b0;
          state_d = ST_LACK;
        end
      end
      ST_LACK: begin
        if (can_load) begin
          ov_d    = 1'b1;
          okind_d = KIND_ACK;
          oseq_d  = seq_q;
          odata_d = '0;
          olast_d = 1'b0;
          state_d = ST_LCLOSE;
        end
      end
      ST_LCLOSE: begin
        if (can_load) begin
          ov_d    = 1'b1;
          okind_d = KIND_CLOSE;
          oseq_d  = seq_q;
          odata_d = '0;
          olast_d = last_q;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      win_q   <= WIN_W'(MAX_WINDOW);
      base_q  <= '0;
      full_q  <= '0;
      idx_q   <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      win_q   <= win_d;
      base_q  <= base_d;
      full_q  <= full_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q   <= seq_d;
    last_q  <= last_d;
    data_q  <= data_d;
    okind_q <= okind_d;
    oseq_q  <= oseq_d;
    odata_q <= odata_d;
    olast_q <= olast_d;
  end

  assign out_valid_o   = ov_q;
  assign result_kind_o = okind_q;
  assign seq_out_o     = oseq_q;
  assign data_out_o    = odata_q;
  assign last_of_run_o = olast_q;

endmodule

@@ rtl/selective_repeat_receive_reorder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_receive_reorder
// Selective-repeat receive window with in-order release of buffered payloads.
// ----------------------------------------------------------------------------
// Sequence: the first result of a packet is loaded into the output
//   register from ACK, or, when it releases stored slots, from DELIV after
//   the slot read in ISSUE. Each stored slot takes ISSUE (slot read) then
//   DELIV (output load); a last packet at the base runs LDELIV, LACK,
//   LCLOSE. No new packet beat is taken until the sequencer is back in IDLE.
// Reset: window 8, base 0, all slot-full bits cleared at once; payload RAM
//   is not cleared (a slot is only read while its full bit is set).
// ----------------------------------------------------------------------------
module selective_repeat_receive_reorder
  import srrr_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // window size register write
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [WIN_W-1:0]        cfg_data_i,
  // packet beats
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [SEQ_W-1:0]        seq_num_i,
  input  logic                    is_last_i,
  input  logic [PAYLOAD_BITS-1:0] payload_i,
  // result beats
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [KIND_W-1:0]       result_kind_o,
  output logic [SEQ_W-1:0]        seq_out_o,
  output logic [PAYLOAD_BITS-1:0] data_out_o,
  output logic                    last_of_run_o
);

  // Control side owns the base, full bits and the result register; the
  // slot RAM only holds payload words. A stored packet is written on its
  // accept edge and the drain reads start the following cycle, so the
  // read always sees the fresh word without forwarding.
  ram_req_t                ram_req;
  logic [PAYLOAD_BITS-1:0] ram_rd;

  srrr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .seq_num_i     (seq_num_i),
    .is_last_i     (is_last_i),
    .payload_i     (payload_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_kind_o (result_kind_o),
    .seq_out_o     (seq_out_o),
    .data_out_o    (data_out_o),
    .last_of_run_o (last_of_run_o),
    .ram_req_o     (ram_req),
    .ram_rd_i      (ram_rd)
  );

  srrr_slot_mem u_mem (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (ram_rd)
  );

endmodule
